>>> src/salc_pkg.sv
// Shared types, codes and helpers of the set-associative LRU cache model.
package salc_pkg;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;
    localparam logic [1:0] MODE_FETCH  = 2'd3;

    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        valid;
        logic [63:0] tag;
        logic [31:0] age;
    } line_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

>>> src/salc_if.sv
// Channel interfaces: access requests, lookup results, register writes.
interface salc_access_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] address;
    modport source (output valid, mode, address, input ready);
    modport sink (input valid, mode, address, output ready);
endinterface

interface salc_result_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic        miss;
    logic        evicted;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
    modport source (output valid, hit, miss, evicted, last, hit_total, miss_total,
                    evict_total, input ready);
    modport sink (input valid, hit, miss, evicted, last, hit_total, miss_total,
                  evict_total, output ready);
endinterface

interface salc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> src/salc_ctrl.sv
// Sequencer: accept requests, step each lookup through read, evaluate and commit.
module salc_ctrl import salc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);
    state_t state_reg, state_next;
    logic   modify_reg, modify_next;
    logic   second_reg, second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            modify_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            modify_reg <= modify_next;
            second_reg <= second_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        modify_next = modify_reg;
        second_next = second_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    modify_next = (in_mode == MODE_MODIFY);
                    second_next = 1'b0;
                    if (in_mode != MODE_FETCH)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the result register can take the new result
                if (!status.out_busy)
                begin
                    cmd.commit = 1'b1;
                    cmd.last   = !(modify_reg && !second_reg);
                    if (modify_reg && !second_reg)
                    begin
                        second_next = 1'b1;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> src/salc_dp.sv
// Datapath: address slicing, set memory, LRU update, victim choice, totals.
module salc_dp import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [63:0] in_address,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_hit,
    output logic        out_miss,
    output logic        out_evicted,
    output logic        out_last,
    output logic [31:0] out_hit_total,
    output logic [31:0] out_miss_total,
    output logic [31:0] out_evict_total
);
    localparam int SW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W  = MAX_WAYS * $bits(line_t);

    typedef line_t [MAX_WAYS-1:0] row_t;

    logic [3:0] sib_reg;
    logic [5:0] ob_reg;
    logic [3:0] wiu_reg;

    logic [SW-1:0]    set_reg;
    logic [63:0]      tag_reg;
    logic [NSETS-1:0] rowv_reg;
    logic             rowq_reg;
    row_t             upd_reg;
    logic             hit_reg;

    logic        ov_reg, o_hit_reg, o_miss_reg, o_ev_reg, o_last_reg;
    logic [31:0] hits_reg, miss_reg, ev_reg;

    logic [4:0]    sbits;
    logic [6:0]    ways;
    logic [6:0]    tsh;
    logic [63:0]   shifted;
    logic [SW-1:0] set_mask;
    logic [SW-1:0] set_next;
    logic [63:0]   tag_next;
    logic [ROW_W-1:0] rd_data;
    row_t          cur_row;
    row_t          upd_next;
    logic          hit_next;
    row_t          wr_row;
    logic [WW-1:0] victim;
    logic          found;
    logic [31:0]   best;
    logic          evict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg <= 4'd4;
            ob_reg  <= 6'd4;
            wiu_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SET_BITS:    sib_reg <= cfg_data[3:0];
                REG_OFFSET_BITS: ob_reg  <= cfg_data[5:0];
                REG_WAYS:        wiu_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // clamp register values and slice the address
    always_comb
    begin
        sbits = ({1'b0, sib_reg} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, sib_reg};
        if (wiu_reg == 4'd0)
            ways = 7'd1;
        else if ({3'b0, wiu_reg} > 7'(MAX_WAYS))
            ways = 7'(MAX_WAYS);
        else
            ways = {3'b0, wiu_reg};
        shifted  = in_address >> ob_reg;
        set_mask = SW'((17'd1 << sbits) - 17'd1);
        set_next = shifted[SW-1:0] & set_mask;
        tsh      = 7'(sbits) + 7'(ob_reg);
        tag_next = (tsh >= 7'd64) ? 64'd0 : (in_address >> tsh[5:0]);
    end

    salc_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (set_reg),
        .wdata (ROW_W'(wr_row)),
        .raddr (set_reg),
        .rdata (rd_data)
    );

    // a row never written reads as all zero
    always_comb
    begin
        cur_row  = rowq_reg ? row_t'(rd_data) : '0;
        upd_next = cur_row;
        hit_next = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (7'(w) < ways && cur_row[w].valid)
            begin
                if (cur_row[w].tag == tag_reg)
                begin
                    upd_next[w].age = 32'd0;
                    hit_next        = 1'b1;
                end
                else
                begin
                    upd_next[w].age = sat_inc(cur_row[w].age);
                end
            end
        end
    end

    // victim: first invalid way, else the oldest, lowest on ties
    always_comb
    begin
        found  = 1'b0;
        best   = 32'd0;
        victim = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (7'(w) < ways && !found)
            begin
                if (!upd_reg[w].valid)
                begin
                    victim = WW'(w);
                    found  = 1'b1;
                end
                else if (upd_reg[w].age > best)
                begin
                    best   = upd_reg[w].age;
                    victim = WW'(w);
                end
            end
        end
        wr_row = upd_reg;
        evict  = 1'b0;
        if (!hit_reg)
        begin
            evict                = upd_reg[victim].valid;
            wr_row[victim].valid = 1'b1;
            wr_row[victim].age   = 32'd0;
            wr_row[victim].tag   = tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg <= set_next;
            tag_reg <= tag_next;
        end
        rowq_reg <= rowv_reg[set_reg];
        if (cmd.eval)
        begin
            upd_reg <= upd_next;
            hit_reg <= hit_next;
        end
        if (cmd.commit)
        begin
            o_hit_reg  <= hit_reg;
            o_miss_reg <= !hit_reg;
            o_ev_reg   <= evict;
            o_last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rowv_reg <= '0;
            ov_reg   <= 1'b0;
            hits_reg <= 32'd0;
            miss_reg <= 32'd0;
            ev_reg   <= 32'd0;
        end
        else
        begin
            if (cmd.commit)
            begin
                rowv_reg[set_reg] <= 1'b1;
                ov_reg            <= 1'b1;
                if (hit_reg)
                    hits_reg <= sat_inc(hits_reg);
                else
                    miss_reg <= sat_inc(miss_reg);
                if (evict)
                    ev_reg <= sat_inc(ev_reg);
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign status.out_busy = ov_reg && !out_ready;
    assign out_valid       = ov_reg;
    assign out_hit         = o_hit_reg;
    assign out_miss        = o_miss_reg;
    assign out_evicted     = o_ev_reg;
    assign out_last        = o_last_reg;
    assign out_hit_total   = hits_reg;
    assign out_miss_total  = miss_reg;
    assign out_evict_total = ev_reg;
endmodule

>>> src/set_assoc_lru_cache_model.sv
// Top level of the tag-only set-associative cache model with LRU replacement.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------------------
//  access   | in  | valid/ready  | mode[1:0], address[63:0]
//  result   | out | valid/ready  | hit, miss, evicted, last, three 32-bit totals
//  cfg      | in  | valid/ready  | index[1:0], data[7:0] (always ready)
//
// A lookup goes through these steps: accept, read the set row from the set memory,
// evaluate tags and ages, then commit the row and load the result register.
// A load or store request makes one lookup, a modify request two back to back
// (the second reads the row the first just wrote), a fetch request none.
// Reset clears the totals and one valid bit per set row; the memory is not swept.
// A held result stalls only the commit step; a new request is accepted while
// the previous result still waits.
module set_assoc_lru_cache_model import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input logic           clk,
    input logic           rst_n,
    salc_access_if.sink   access,
    salc_result_if.source result,
    salc_cfg_if.sink      cfg
);
    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (access.valid),
        .in_mode  (access.mode),
        .in_ready (access.ready),
        .status   (status),
        .cmd      (cmd)
    );

    salc_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_address      (access.address),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_hit         (result.hit),
        .out_miss        (result.miss),
        .out_evicted     (result.evicted),
        .out_last        (result.last),
        .out_hit_total   (result.hit_total),
        .out_miss_total  (result.miss_total),
        .out_evict_total (result.evict_total)
    );
endmodule

>>> test/salc_tb_if.sv
// Testbench types: the record of one expected lookup result.
package salc_tb_types;
    timeunit 1ns;
    timeprecision 1ps;
    typedef struct packed {
        logic        hit;
        logic        miss;
        logic        evicted;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } lookup_res_t;
endpackage

>>> test/tb.sv
// Testbench of the set-associative LRU cache model: random traces checked against a predictor.
module tb;
    import salc_pkg::*;
    import salc_tb_types::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_BITS_MAX = 8;
    localparam int WAYS_MAX     = 8;
    localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    salc_access_if access ();
    salc_result_if result ();
    salc_cfg_if    cfg ();

    set_assoc_lru_cache_model dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .access (access.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Advance the clock every half period.
    always #4 clk = ~clk;

    // Predictor copy of the cache contents and settings.
    logic        pv_valid [LINES];
    logic [63:0] pv_tag   [LINES];
    logic [31:0] pv_age   [LINES];
    logic [31:0] cnt_hit, cnt_miss, cnt_evict;
    logic [3:0]  cur_set_bits;
    logic [5:0]  cur_offset;
    logic [3:0]  cur_ways;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
    } request_t;

    request_t    pending_requests [$];
    lookup_res_t expected_lookups [$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          stim_done = 1'b0;
    bit          access_taken = 1'b0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] shift_right(input logic [63:0] v, input int n);
        return (n >= 64) ? 64'd0 : (v >> n);
    endfunction

    // Predict one lookup and push the expected result.
    function automatic void predict_lookup(input logic [63:0] addr, input logic is_last);
        int          sbits;
        int          ways;
        int          set_idx;
        int          base;
        int          victim;
        logic [63:0] tag;
        logic [31:0] best;
        logic        got_hit;
        logic        got_evict;
        lookup_res_t r;
        sbits = (cur_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cur_set_bits;
        ways = (cur_ways == 0) ? 1 : ((cur_ways > WAYS_MAX) ? WAYS_MAX : cur_ways);
        set_idx = int'(shift_right(addr, cur_offset) & ((64'd1 << sbits) - 1));
        tag = shift_right(addr, sbits + cur_offset);
        base = set_idx * WAYS_MAX;
        got_hit = 1'b0;
        got_evict = 1'b0;
        for (int w = 0; w < ways; w++) begin
            if (pv_valid[base + w] && pv_tag[base + w] == tag) begin
                pv_age[base + w] = 32'd0;
                got_hit = 1'b1;
            end
            else if (pv_valid[base + w]) begin
                pv_age[base + w] = bump(pv_age[base + w]);
            end
        end
        if (got_hit) begin
            cnt_hit = bump(cnt_hit);
        end
        else begin
            cnt_miss = bump(cnt_miss);
            victim = 0;
            best = 32'd0;
            for (int w = 0; w < ways; w++) begin
                if (!pv_valid[base + w]) begin
                    victim = w;
                    break;
                end
                if (pv_age[base + w] > best) begin
                    best = pv_age[base + w];
                    victim = w;
                end
            end
            if (pv_valid[base + victim]) begin
                got_evict = 1'b1;
                cnt_evict = bump(cnt_evict);
            end
            pv_valid[base + victim] = 1'b1;
            pv_age[base + victim] = 32'd0;
            pv_tag[base + victim] = tag;
        end
        r.hit = got_hit;
        r.miss = !got_hit;
        r.evicted = got_evict;
        r.last = is_last;
        r.hit_total = cnt_hit;
        r.miss_total = cnt_miss;
        r.evict_total = cnt_evict;
        expected_lookups.push_back(r);
    endfunction

    function automatic void predict_request(input request_t q);
        if (q.mode == MODE_MODIFY) begin
            predict_lookup(q.address, 1'b0);
            predict_lookup(q.address, 1'b1);
        end
        else if (q.mode != MODE_FETCH) begin
            predict_lookup(q.address, 1'b1);
        end
    endfunction

    // Driver: present queued requests at the falling edge, drop valid on idle cycles;
    // advance only after the request on the port was taken at the last rising edge.
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            access.valid <= 1'b0;
            access.mode <= MODE_LOAD;
            access.address <= 64'd0;
        end
        else if (!access.valid || access_taken) begin
            if (pending_requests.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                access.valid <= 1'b1;
                access.mode <= pending_requests[0].mode;
                access.address <= pending_requests[0].address;
            end
            else begin
                access.valid <= 1'b0;
            end
        end
    end

    // Track acceptance at the rising edge and flag it for the driver.
    always @(posedge clk) begin
        access_taken <= rst_n && access.valid && access.ready;
        if (rst_n && access.valid && access.ready) begin
            predict_request(pending_requests.pop_front());
        end
    end

    // Receiver stalls at random.
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            result.ready <= 1'b0;
        end
        else begin
            result.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic report(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
        fail_count++;
    endtask

    // Monitor: compare every accepted result with the oldest expectation.
    always @(posedge clk) begin
        lookup_res_t e;
        if (rst_n && result.valid && result.ready) begin
            if (expected_lookups.size() == 0) begin
                $error("result with no expected lookup pending");
                fail_count++;
            end
            else begin
                e = expected_lookups.pop_front();
                if (result.hit !== e.hit) report("hit", e.hit, result.hit);
                if (result.miss !== e.miss) report("miss", e.miss, result.miss);
                if (result.evicted !== e.evicted) report("evicted", e.evicted, result.evicted);
                if (result.last !== e.last) report("last", e.last, result.last);
                if (result.hit_total !== e.hit_total)
                    report("hit_total", e.hit_total, result.hit_total);
                if (result.miss_total !== e.miss_total)
                    report("miss_total", e.miss_total, result.miss_total);
                if (result.evict_total !== e.evict_total)
                    report("evict_total", e.evict_total, result.evict_total);
            end
        end
    end

    // Hold until every queued request is taken and every result has arrived,
    // then let the pipeline drain.
    task automatic drain();
        while (pending_requests.size() > 0 || expected_lookups.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == REG_SET_BITS) cur_set_bits = value[3:0];
        else if (idx == REG_OFFSET_BITS) cur_offset = value[5:0];
        else if (idx == REG_WAYS) cur_ways = value[3:0];
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic configure(input int sb, input int ob, input int wy);
        drain();
        write_reg(REG_SET_BITS, 8'(sb));
        write_reg(REG_OFFSET_BITS, 8'(ob));
        write_reg(REG_WAYS, 8'(wy));
    endtask

    function automatic void queue_req(input logic [1:0] m, input logic [63:0] a);
        request_t q;
        q.mode = m;
        q.address = a;
        pending_requests.push_back(q);
    endfunction

    // Random access: mostly reuse of a small pool of block addresses so sets
    // fill, age and evict; the rest is wide noise over the whole address.
    function automatic logic [63:0] pick_address(ref logic [63:0] pool [8]);
        logic [63:0] a;
        if ($urandom_range(99, 0) < 80) begin
            a = pool[$urandom_range(7, 0)];
            if ($urandom_range(3, 0) == 0) a[3:0] = 4'($urandom);
        end
        else begin
            a = {$urandom, $urandom};
            if ($urandom_range(1, 0)) pool[$urandom_range(7, 0)] = a;
        end
        return a;
    endfunction

    task automatic random_phase(input int count, input int sb, input int ob, input int wy);
        logic [63:0] pool [8];
        configure(sb, ob, wy);
        for (int i = 0; i < 8; i++)
            pool[i] = {$urandom, $urandom};
        for (int i = 0; i < count; i++)
            queue_req(2'($urandom_range(3, 0)), pick_address(pool));
    endtask

    // Stimulus and phase control.
    initial begin
        cfg.valid = 1'b0;
        cfg.index = REG_SET_BITS;
        cfg.data = 8'd0;
        for (int i = 0; i < LINES; i++) begin
            pv_valid[i] = 1'b0;
            pv_tag[i] = 64'd0;
            pv_age[i] = 32'd0;
        end
        cnt_hit = 0;
        cnt_miss = 0;
        cnt_evict = 0;
        cur_set_bits = 4;
        cur_offset = 4;
        cur_ways = 1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, every mode, address extremes.
        send_idle_pct = 28;
        recv_idle_pct = 63;
        queue_req(MODE_LOAD, 64'd0);
        queue_req(MODE_STORE, 64'd0);
        queue_req(MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_req(MODE_FETCH, 64'h1234);
        queue_req(MODE_LOAD, 64'h0000_0000_0000_0100);
        queue_req(MODE_LOAD, 64'd0);
        // Many ways, oversize set bits, tag shifts of 64 and of 63.
        configure(15, 0, 15);
        for (int i = 0; i < 10; i++)
            queue_req(MODE_LOAD, 64'(i) << 8);
        queue_req(MODE_MODIFY, 64'h0);
        configure(8, 56, 0);
        queue_req(MODE_LOAD, 64'hFF00_0000_0000_0000);
        queue_req(MODE_STORE, 64'h0100_0000_0000_0000);
        configure(0, 63, 2);
        queue_req(MODE_LOAD, 64'hAAAA_5555_AAAA_5555);
        queue_req(MODE_LOAD, 64'h5555_AAAA_5555_AAAA);
        // Change slicing over live contents to get several matching ways.
        configure(0, 0, 8);
        queue_req(MODE_LOAD, 64'h0);
        queue_req(MODE_LOAD, 64'h1);

        random_phase(250, 4, 4, 4);
        random_phase(250, 2, 0, 8);
        send_idle_pct = 63;
        recv_idle_pct = 28;
        random_phase(250, 8, 32, 1);
        random_phase(250, 1, 6, 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(250, 0, 2, 8);
        random_phase(250, 3, 5, 2);
        drain();
        stim_done = 1'b1;
    end

    // Final verdict.
    initial begin
        wait (stim_done);
        if (fail_count == 0 && expected_lookups.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout guard.
    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
